@@ hw/rtl/row_height_range_profiler_top_macros.svh @@
// ----------------------------------------------------------------------------
// Row height range profiler: assertion macros
// Clocked on clk; the checked form is gated off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ROW_HEIGHT_RANGE_PROFILER_TOP_MACROS_SVH
`define ROW_HEIGHT_RANGE_PROFILER_TOP_MACROS_SVH

// Checked only out of reset.
`define RHRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define RHRP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/rhrp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhrp_pkg
// Shared constants and types of the row height range profiler.
// ----------------------------------------------------------------------------
package rhrp_pkg;

  localparam int unsigned RHRP_COORD_BITS = 32;
  localparam int unsigned AXIS_BITS       = 2;

  localparam logic [AXIS_BITS-1:0] AXIS_KEY_Y_MEAS_Z = 2'd0;
  localparam logic [AXIS_BITS-1:0] AXIS_KEY_X_MEAS_Z = 2'd1;
  localparam logic [AXIS_BITS-1:0] AXIS_KEY_Y_MEAS_X = 2'd2;

  localparam int unsigned RES_DEPTH  = 4;
  localparam int unsigned RES_PTR_W  = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W  = $clog2(RES_DEPTH + 1);

  // Result queue push request: none, one or two words per point.
  typedef struct packed {
    logic push0;
    logic push1;
  } rhrp_push_t;

  // Result queue status seen by the tracker.
  typedef struct packed {
    logic                 has_room;
    logic [RES_CNT_W-1:0] count;
  } rhrp_q_stat_t;

endpackage

@@ hw/rtl/rhrp_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhrp interfaces
// Point, result and configuration channels (valid/ready).
// ----------------------------------------------------------------------------
interface rhrp_in_if import rhrp_pkg::*; #(
  parameter int unsigned COORD_BITS = RHRP_COORD_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] x_coord;
  logic signed [COORD_BITS-1:0] y_coord;
  logic signed [COORD_BITS-1:0] z_coord;
  logic                         end_of_cloud;

  modport source (output valid, x_coord, y_coord, z_coord, end_of_cloud, input ready);
  modport sink   (input valid, x_coord, y_coord, z_coord, end_of_cloud, output ready);
endinterface

interface rhrp_out_if import rhrp_pkg::*; #(
  parameter int unsigned COORD_BITS = RHRP_COORD_BITS
);
  logic                         valid;
  logic                         ready;
  logic        [COORD_BITS-1:0] row_range;
  logic signed [COORD_BITS-1:0] row_key;
  logic                         last_result;

  modport source (output valid, row_range, row_key, last_result, input ready);
  modport sink   (input valid, row_range, row_key, last_result, output ready);
endinterface

interface rhrp_cfg_if import rhrp_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [AXIS_BITS-1:0] axis_mode;

  modport source (output valid, axis_mode, input ready);
  modport sink   (input valid, axis_mode, output ready);
endinterface

@@ hw/rtl/rhrp_row_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhrp_row_tracker
// Point register, open-row state and per-point result generation.
// ----------------------------------------------------------------------------
module rhrp_row_tracker import rhrp_pkg::*; #(
  parameter int unsigned COORD_BITS = RHRP_COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_x,
  input  logic signed [COORD_BITS-1:0] in_y,
  input  logic signed [COORD_BITS-1:0] in_z,
  input  logic                         in_eoc,
  input  logic [AXIS_BITS-1:0]         axis_mode,
  input  rhrp_q_stat_t                 q_stat,
  output rhrp_push_t                   push,
  output logic [2*COORD_BITS:0]        res0,
  output logic [2*COORD_BITS:0]        res1
);

  logic                         s1_valid_r;
  logic signed [COORD_BITS-1:0] s1_x_r, s1_y_r, s1_z_r;
  logic                         s1_eoc_r;

  logic                         row_open_r, row_open_nxt;
  logic signed [COORD_BITS-1:0] cur_key_r, cur_key_nxt;
  logic signed [COORD_BITS-1:0] low_r, low_nxt;
  logic signed [COORD_BITS-1:0] high_r, high_nxt;

  logic                         fire;
  logic signed [COORD_BITS-1:0] key, val;
  logic                         hit;
  logic                         close_old;
  logic [2*COORD_BITS:0]        res_old, res_eoc;
  logic [COORD_BITS-1:0]        eoc_range;

  assign fire     = s1_valid_r && q_stat.has_room;
  assign in_ready = !s1_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_x_r   <= in_x;
      s1_y_r   <= in_y;
      s1_z_r   <= in_z;
      s1_eoc_r <= in_eoc;
    end
  end

  always_comb begin
    key = (axis_mode == AXIS_KEY_X_MEAS_Z) ? s1_x_r : s1_y_r;
    val = (axis_mode == AXIS_KEY_Y_MEAS_X) ? s1_x_r : s1_z_r;
    hit       = row_open_r && (key == cur_key_r);
    close_old = row_open_r && !hit;

    row_open_nxt = row_open_r;
    cur_key_nxt  = cur_key_r;
    low_nxt      = low_r;
    high_nxt     = high_r;
    if (fire) begin
      row_open_nxt = !s1_eoc_r;
      if (hit) begin
        if (val < low_r) begin
          low_nxt = val;
        end else if (high_r < val) begin
          high_nxt = val;
        end
      end else begin
        cur_key_nxt = key;
        low_nxt     = val;
        high_nxt    = val;
      end
    end

    // Flushed row: extremes after this point, or a fresh one-point row.
    eoc_range = hit ? COORD_BITS'(high_nxt - low_nxt) : '0;
    res_old   = {COORD_BITS'(high_r - low_r), cur_key_r, !s1_eoc_r};
    res_eoc   = {eoc_range, key, 1'b1};

    push.push0 = fire && (close_old || s1_eoc_r);
    push.push1 = fire && close_old && s1_eoc_r;
    res0       = close_old ? res_old : res_eoc;
    res1       = res_eoc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_open_r <= 1'b0;
      cur_key_r  <= '0;
      low_r      <= '0;
      high_r     <= '0;
    end else begin
      row_open_r <= row_open_nxt;
      cur_key_r  <= cur_key_nxt;
      low_r      <= low_nxt;
      high_r     <= high_nxt;
    end
  end

endmodule

@@ hw/rtl/rhrp_res_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhrp_res_queue
// Small result queue: takes one or two words a cycle, gives one.
// ----------------------------------------------------------------------------
module rhrp_res_queue import rhrp_pkg::*; #(
  parameter int unsigned COORD_BITS = RHRP_COORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rhrp_push_t            push,
  input  logic [2*COORD_BITS:0] wdata0,
  input  logic [2*COORD_BITS:0] wdata1,
  output rhrp_q_stat_t          q_stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2*COORD_BITS:0] rdata
);

  logic [2*COORD_BITS:0] mem [RES_DEPTH];
  logic [RES_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [RES_CNT_W-1:0]  count_r, count_nxt;
  logic                  pop;
  logic [RES_PTR_W-1:0]  wr_ptr1;

  assign out_valid       = (count_r != '0);
  assign pop             = out_valid && out_ready;
  assign rdata           = mem[rd_ptr_r];
  assign wr_ptr1         = wr_ptr_r + RES_PTR_W'(1);
  assign q_stat.count    = count_r;
  assign q_stat.has_room = (count_r <= RES_CNT_W'(RES_DEPTH - 2));

  always_comb begin
    count_nxt = count_r + RES_CNT_W'(push.push0) + RES_CNT_W'(push.push1)
                - RES_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem[wr_ptr_r] <= wdata0;
    end
    if (push.push1) begin
      mem[wr_ptr1] <= wdata1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push.push1) begin
        wr_ptr_r <= wr_ptr_r + RES_PTR_W'(2);
      end else if (push.push0) begin
        wr_ptr_r <= wr_ptr1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + RES_PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

@@ hw/rtl/row_height_range_profiler_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_height_range_profiler_top
// Per-row min/max tracking of a streamed point cloud; emits row ranges.
// ----------------------------------------------------------------------------
// Path: with the queue empty, an accepted point waits in the point register, then
//   its first word is written to the result queue and offered from there.
// Throughput: one point per cycle while fewer than 3 words are queued; a point
//   yields 0, 1 or 2 words and the 4-entry result queue drains one word per
//   cycle, so the input waits when the result side stalls or flush pairs pile up.
// Reset: rst_n synchronous, active low; clears open row, queue and mode (0).
// ----------------------------------------------------------------------------
`include "row_height_range_profiler_top_macros.svh"

module row_height_range_profiler_top import rhrp_pkg::*; #(
  parameter int unsigned COORD_BITS = RHRP_COORD_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  rhrp_in_if.sink    in_chan,
  rhrp_out_if.source out_chan,
  rhrp_cfg_if.sink   cfg_chan
);

  logic [AXIS_BITS-1:0]  axis_mode_r;
  rhrp_push_t            push;
  rhrp_q_stat_t          q_stat;
  logic [2*COORD_BITS:0] res0, res1, rdata;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_mode_r <= AXIS_KEY_Y_MEAS_Z;
    end else if (cfg_chan.valid) begin
      axis_mode_r <= cfg_chan.axis_mode;
    end
  end

  rhrp_row_tracker #(.COORD_BITS(COORD_BITS)) u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_x      (in_chan.x_coord),
    .in_y      (in_chan.y_coord),
    .in_z      (in_chan.z_coord),
    .in_eoc    (in_chan.end_of_cloud),
    .axis_mode (axis_mode_r),
    .q_stat    (q_stat),
    .push      (push),
    .res0      (res0),
    .res1      (res1)
  );

  rhrp_res_queue #(.COORD_BITS(COORD_BITS)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wdata0    (res0),
    .wdata1    (res1),
    .q_stat    (q_stat),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .rdata     (rdata)
  );

  assign out_chan.row_range   = rdata[2*COORD_BITS:COORD_BITS+1];
  assign out_chan.row_key     = rdata[COORD_BITS:1];
  assign out_chan.last_result = rdata[0];

  `RHRP_ASSERT(a_q_bound, q_stat.count <= RES_CNT_W'(RES_DEPTH), "result queue overflow")
  `RHRP_ASSERT(a_pair_push, push.push1 |-> push.push0, "second word pushed without first")
  `RHRP_ASSERT(a_pair_out, (out_chan.valid && out_chan.ready && !out_chan.last_result) |=> out_chan.valid, "closed row word not followed by its partner")
  `RHRP_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_chan.valid, "result offered right after reset")

endmodule

@@ dv/rhrp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhrp_checker
// Watches the point, result and mode channels of the row height range
// profiler. It keeps its own copy of the open row and the axis mode, predicts
// the row range words that each accepted point closes, and compares every
// accepted result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module rhrp_checker import rhrp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  rhrp_in_if          pts,
  rhrp_out_if         res,
  rhrp_cfg_if         cfg,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned point_count,
  output int unsigned word_count,
  output int unsigned pair_count
);

  localparam int unsigned CB = RHRP_COORD_BITS;

  typedef struct packed {
    logic        [CB-1:0] span;
    logic signed [CB-1:0] key;
    logic                 is_last;
  } row_word_t;

  row_word_t expected_rows[$];

  logic [AXIS_BITS-1:0] axis_sel;
  logic                 row_open;
  logic signed [CB-1:0] open_key;
  logic signed [CB-1:0] row_lo;
  logic signed [CB-1:0] row_hi;

  function automatic row_word_t close_row(logic is_last);
    row_word_t w;
    w.span    = row_hi - row_lo;
    w.key     = open_key;
    w.is_last = is_last;
    return w;
  endfunction

  function automatic void open_row(logic signed [CB-1:0] key, logic signed [CB-1:0] val);
    row_open = 1'b1;
    open_key = key;
    row_lo   = val;
    row_hi   = val;
  endfunction

  function automatic void take_point(logic signed [CB-1:0] x, logic signed [CB-1:0] y,
                                     logic signed [CB-1:0] z, logic eoc);
    logic signed [CB-1:0] key;
    logic signed [CB-1:0] val;
    int unsigned          n;
    key = (axis_sel == AXIS_KEY_X_MEAS_Z) ? x : y;
    val = (axis_sel == AXIS_KEY_Y_MEAS_X) ? x : z;
    n   = 0;
    if (!row_open) begin
      open_row(key, val);
    end else if (key == open_key) begin
      if (val < row_lo) begin
        row_lo = val;
      end else if (val > row_hi) begin
        row_hi = val;
      end
    end else begin
      expected_rows = {expected_rows, close_row(!eoc)};
      n++;
      open_row(key, val);
    end
    if (eoc) begin
      expected_rows = {expected_rows, close_row(1'b1)};
      n++;
      row_open = 1'b0;
    end
    point_count++;
    if (n == 2) pair_count++;
  endfunction

  function automatic void check_word();
    row_word_t got;
    row_word_t want;
    got.span    = res.row_range;
    got.key     = res.row_key;
    got.is_last = res.last_result;
    word_count++;
    if (expected_rows.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("[%0t] unexpected word: range %h key %h last %b",
                 $time, got.span, got.key, got.is_last);
      end
      return;
    end
    want = expected_rows.pop_front();
    if (got.span !== want.span || got.key !== want.key || got.is_last !== want.is_last) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("[%0t] word mismatch: exp range %h key %h last %b, got range %h key %h last %b",
                 $time, want.span, want.key, want.is_last, got.span, got.key, got.is_last);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      axis_sel = AXIS_KEY_Y_MEAS_Z;
      row_open = 1'b0;
      open_key = '0;
      row_lo   = '0;
      row_hi   = '0;
      expected_rows.delete();
    end else begin
      if (res.valid && res.ready) check_word();
      if (cfg.valid && cfg.ready) axis_sel = cfg.axis_mode;
      if (pts.valid && pts.ready) begin
        take_point(pts.x_coord, pts.y_coord, pts.z_coord, pts.end_of_cloud);
      end
    end
    pending = expected_rows.size();
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives scanned points into the row height range profiler: a short directed
// run over value extremes, first-point flushes, key change with flush and
// mode changes inside an open row, then random rows of shared keys in every
// axis mode with random gaps and result stalls. The checker scores results.
// ----------------------------------------------------------------------------
module testbench;
  import rhrp_pkg::*;

  localparam int unsigned          CB           = RHRP_COORD_BITS;
  localparam logic [AXIS_BITS-1:0] AXIS_SPARE   = 2'd3;
  localparam int unsigned          POINT_TARGET = 1850;
  localparam int unsigned          QUIET_LIMIT  = 2000;
  localparam int unsigned          DRAIN_CYCLES = 4;
  localparam int unsigned          TAIL_CYCLES  = 10;

  localparam logic signed [CB-1:0] C_MIN = {1'b1, {(CB-1){1'b0}}};
  localparam logic signed [CB-1:0] C_MAX = {1'b0, {(CB-1){1'b1}}};

  logic clk;
  logic rst_n;

  rhrp_in_if  in_if ();
  rhrp_out_if out_if ();
  rhrp_cfg_if cfg_if ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned point_count;
  int unsigned word_count;
  int unsigned pair_count;

  logic [AXIS_BITS-1:0] cur_mode;
  logic                 gaps_on;
  int unsigned          sent;
  int unsigned          quiet_cycles;

  row_height_range_profiler_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  rhrp_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pts         (in_if),
    .res         (out_if),
    .cfg         (cfg_if),
    .fail_count  (fail_count),
    .pending     (pending),
    .point_count (point_count),
    .word_count  (word_count),
    .pair_count  (pair_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [CB-1:0] pick_extreme();
    case ($urandom_range(0, 3))
      0: return C_MIN;
      1: return C_MAX;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic signed [CB-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return pick_extreme();
    if (r < 30) return $urandom_range(0, 7);
    return $urandom;
  endfunction

  function automatic logic signed [CB-1:0] pick_meas(logic signed [CB-1:0] base);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return base + $signed($urandom_range(0, 2000)) - 1000;
    if (r < 80) return $urandom;
    return pick_extreme();
  endfunction

  // called at a rising edge; returns at the edge where the word was taken, or after the random gap that follows it
  task automatic push_point(logic signed [CB-1:0] x, logic signed [CB-1:0] y,
                            logic signed [CB-1:0] z, logic eoc);
    logic        acc;
    int unsigned g;
    in_if.valid        <= 1'b1;
    in_if.x_coord      <= x;
    in_if.y_coord      <= y;
    in_if.z_coord      <= z;
    in_if.end_of_cloud <= eoc;
    do begin
      @(negedge clk);
      acc = in_if.ready;
      @(posedge clk);
    end while (!acc);
    sent++;
    g = gaps_on ? pick_gap() : 0;
    if (g > 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic push_kv(logic signed [CB-1:0] key, logic signed [CB-1:0] meas, logic eoc);
    if (cur_mode == AXIS_KEY_X_MEAS_Z) begin
      push_point(key, $urandom, meas, eoc);
    end else if (cur_mode == AXIS_KEY_Y_MEAS_X) begin
      push_point(meas, key, $urandom, eoc);
    end else begin
      push_point($urandom, key, meas, eoc);
    end
  endtask

  task automatic hold_until_drained();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(logic [AXIS_BITS-1:0] m);
    logic acc;
    hold_until_drained();
    cfg_if.valid     <= 1'b1;
    cfg_if.axis_mode <= m;
    do begin
      @(negedge clk);
      acc = cfg_if.ready;
      @(posedge clk);
    end while (!acc);
    cfg_if.valid <= 1'b0;
    cur_mode = m;
  endtask

  task automatic push_row();
    logic signed [CB-1:0] key;
    logic signed [CB-1:0] base;
    int unsigned          len;
    if ($urandom_range(0, 99) < 12) begin
      push_point($urandom, $urandom, $urandom, $urandom_range(0, 9) == 0);
      return;
    end
    key  = pick_key();
    base = $urandom;
    len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
    for (int unsigned i = 0; i < len; i++) begin
      push_kv(key, pick_meas(base), (i == len - 1) && ($urandom_range(0, 6) == 0));
    end
  endtask

  // result side: ready runs with stalls, now and then a long stretch without
  initial begin
    int unsigned run;
    int unsigned stall;
    out_if.ready <= 1'b0;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      repeat (run) begin
        @(posedge clk);
        out_if.ready <= 1'b1;
      end
      stall = pick_gap();
      repeat (stall) begin
        @(posedge clk);
        out_if.ready <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                 (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned phase;
    int unsigned phase_end;
    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.x_coord      <= '0;
    in_if.y_coord      <= '0;
    in_if.z_coord      <= '0;
    in_if.end_of_cloud <= 1'b0;
    cfg_if.valid       <= 1'b0;
    cfg_if.axis_mode   <= AXIS_KEY_Y_MEAS_Z;
    cur_mode = AXIS_KEY_Y_MEAS_Z;
    gaps_on  = 1'b1;
    sent     = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    push_kv(32'sh100, 32'sh500, 1'b1);
    push_kv(32'sh10, 32'sd50, 1'b0);
    push_kv(32'sh10, 32'sd30, 1'b0);
    push_kv(32'sh10, 32'sd10, 1'b0);
    push_kv(32'sh10, 32'sd40, 1'b0);
    push_kv(C_MIN, C_MAX, 1'b0);
    push_kv(C_MIN, C_MIN, 1'b0);
    push_kv(C_MAX, '0, 1'b1);
    push_kv('1, 32'sd7, 1'b0);
    set_mode(AXIS_KEY_X_MEAS_Z);
    push_kv('1, -32'sd9, 1'b0);
    push_kv('0, 32'sd3, 1'b1);
    set_mode(AXIS_KEY_Y_MEAS_X);
    push_kv(32'sd5, C_MIN, 1'b0);
    push_kv(32'sd5, '1, 1'b0);
    push_kv(32'sd5, C_MAX, 1'b1);
    set_mode(AXIS_SPARE);
    push_kv(32'sd3, 32'sd1, 1'b0);
    push_kv(32'sd3, 32'sd2, 1'b0);
    push_kv(32'sd4, '0, 1'b0);
    push_kv(32'sd4, '0, 1'b1);

    // random phases, each under its own mode
    phase = 0;
    while (sent < POINT_TARGET) begin
      set_mode((phase < 4) ? phase[AXIS_BITS-1:0] : AXIS_BITS'($urandom_range(0, 3)));
      gaps_on   = ($urandom_range(0, 3) != 0);
      phase_end = sent + $urandom_range(100, 300);
      while (sent < phase_end && sent < POINT_TARGET) begin
        if ($urandom_range(0, 99) < 3) hold_until_drained();
        push_row();
      end
      phase++;
    end

    in_if.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d points and %0d row words in %0d mode phases, axis modes 0 to 3;",
             point_count, word_count, phase);
    $display("  %0d points closed a row and flushed the cloud together.", pair_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
